// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Non-overlapping implication: the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/accalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Operation codes, request and response payloads, and flag types shared by
// the accumulator ALU modules.
// ----------------------------------------------------------------------------
package accalu_pkg;

  // Operation codes of the request.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SLA  = 5'd14,
    OP_SRA  = 5'd15,
    OP_SWAP = 5'd16,
    OP_SRL  = 5'd17,
    OP_RLCA = 5'd18,
    OP_RRCA = 5'd19,
    OP_RLA  = 5'd20,
    OP_RRA  = 5'd21,
    OP_BIT  = 5'd22,
    OP_RES  = 5'd23,
    OP_SET  = 5'd24,
    OP_DAA  = 5'd25,
    OP_CPL  = 5'd26,
    OP_CCF  = 5'd27,
    OP_SCF  = 5'd28,
    OP_LDA  = 5'd29
  } op_e;

  // Rotate and shift kinds, shared by the operand and accumulator forms.
  typedef enum logic [2:0] {
    ROT_RLC  = 3'd0,
    ROT_RRC  = 3'd1,
    ROT_RL   = 3'd2,
    ROT_RR   = 3'd3,
    ROT_SLA  = 3'd4,
    ROT_SRA  = 3'd5,
    ROT_SWAP = 3'd6,
    ROT_SRL  = 3'd7
  } rot_e;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  typedef struct packed {
    logic [4:0] operation;
    logic [7:0] operand;
    logic [2:0] bit_index;
  } in_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic       flag_zero;
    logic       flag_subtract;
    logic       flag_half_carry;
    logic       flag_carry;
  } out_rsp_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // Outcome of one operation as the execute logic produces it.
  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
    logic       acc_we;
  } exec_rsp_t;

endpackage

// ===== rtl/core/accumulator_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU with flags
// Eight-bit accumulator ALU that keeps A and the Z/N/H/C flags.
// ----------------------------------------------------------------------------
// Usage:
// A request (operation, operand, bit index) enters on the in_valid_i /
// in_ready_o channel. Each request yields exactly one response on the
// out_valid_o / out_ready_i channel: the new byte and the four flags.
// The request is held in an input register; the execute logic evaluates it
// against the accumulator and flags, and the response register, accumulator
// and flags are loaded together once the response register is free or drains.
// A response thus passes the input register and the response register before
// it is visible on the out_valid_o / out_ready_i channel.
// Throughput is one request per cycle while the receiver takes responses:
// the accumulator and flags are written in the same cycle the response is
// formed, so the next request sees them. When the receiver stalls, the
// response register holds its value, the input register still takes one more
// request, and in_ready_o then drops until the response is taken.
// Reset clears the accumulator, all flags and both valid bits.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags import accalu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  logic      in_vld_q;
  in_req_t   in_req_q;
  logic      out_vld_q;
  out_rsp_t  out_rsp_q;
  logic [7:0] acc_q;
  flags_t    flags_q;
  exec_rsp_t exec_rsp;
  logic      advance;
  logic      in_take;

  // The input register moves on when the response register is free or drains.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  accalu_exec u_exec (
    .req_i   (in_req_q),
    .acc_i   (acc_q),
    .flags_i (flags_q),
    .rsp_o   (exec_rsp)
  );

  // Valid bits and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= 8'd0;
      flags_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        flags_q   <= exec_rsp.flags;
        if (exec_rsp.acc_we) begin
          acc_q <= exec_rsp.result;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= '{result:          exec_rsp.result,
                     flag_zero:       exec_rsp.flags.z,
                     flag_subtract:   exec_rsp.flags.n,
                     flag_half_carry: exec_rsp.flags.h,
                     flag_carry:      exec_rsp.flags.c};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/core/accalu_exec.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU execute logic
// Combinational evaluation of one request against the current accumulator
// and flags: the result byte, the new flags and the accumulator write enable.
// ----------------------------------------------------------------------------
module accalu_exec import accalu_pkg::*; (
  input  in_req_t    req_i,
  input  logic [7:0] acc_i,
  input  flags_t     flags_i,
  output exec_rsp_t  rsp_o
);

  logic [7:0] a;
  logic [7:0] v;
  logic       cin;
  op_e        op;

  assign a   = acc_i;
  assign v   = req_i.operand;
  assign cin = flags_i.c;
  assign op  = op_e'(req_i.operation);

  // Adder and subtractor with carry or borrow in, full byte and low nibble.
  logic       use_cin;
  logic [8:0] add_full;
  logic [4:0] add_half;
  logic [8:0] sub_full;
  logic [4:0] sub_half;

  assign use_cin  = (op == OP_ADC) || (op == OP_SBC) ? cin : 1'b0;
  assign add_full = {1'b0, a} + {1'b0, v} + {8'd0, use_cin};
  assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_cin};
  assign sub_full = {1'b0, a} - {1'b0, v} - {8'd0, use_cin};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_cin};

  // Rotates and shifts work on the accumulator for the short forms.
  logic       rot_on_acc;
  logic [7:0] rot_x;
  rot_e       rot_kind;
  logic [7:0] rot_r;
  logic       rot_co;

  assign rot_on_acc = (req_i.operation >= OP_RLCA);
  assign rot_x      = rot_on_acc ? a : v;
  assign rot_kind   = rot_on_acc ? rot_e'(3'(req_i.operation - OP_RLCA))
                                 : rot_e'(3'(req_i.operation - OP_RLC));

  always_comb begin
    case (rot_kind)
      ROT_RLC: begin
        rot_co = rot_x[7];
        rot_r  = {rot_x[6:0], rot_x[7]};
      end
      ROT_RRC: begin
        rot_co = rot_x[0];
        rot_r  = {rot_x[0], rot_x[7:1]};
      end
      ROT_RL: begin
        rot_co = rot_x[7];
        rot_r  = {rot_x[6:0], cin};
      end
      ROT_RR: begin
        rot_co = rot_x[0];
        rot_r  = {cin, rot_x[7:1]};
      end
      ROT_SLA: begin
        rot_co = rot_x[7];
        rot_r  = {rot_x[6:0], 1'b0};
      end
      ROT_SRA: begin
        rot_co = rot_x[0];
        rot_r  = {rot_x[7], rot_x[7:1]};
      end
      ROT_SWAP: begin
        rot_co = 1'b0;
        rot_r  = {rot_x[3:0], rot_x[7:4]};
      end
      default: begin
        rot_co = rot_x[0];
        rot_r  = {1'b0, rot_x[7:1]};
      end
    endcase
  end

  // Single-bit mask for the bit test, reset and set operations.
  logic [7:0] bit_mask;
  assign bit_mask = 8'h01 << req_i.bit_index;

  // Decimal adjust after an add or a subtract.
  logic       daa_hi;
  logic       daa_lo;
  logic [7:0] daa_r;
  logic       daa_c;

  assign daa_hi = cin || (a > DAA_HI_LIM);
  assign daa_lo = flags_i.h || (a[3:0] > DAA_LO_LIM);

  always_comb begin
    if (!flags_i.n) begin
      daa_r = a + (daa_hi ? DAA_HI_ADJ : 8'h00) + (daa_lo ? DAA_LO_ADJ : 8'h00);
      daa_c = daa_hi;
    end else begin
      daa_r = a - (cin ? DAA_HI_ADJ : 8'h00) - (flags_i.h ? DAA_LO_ADJ : 8'h00);
      daa_c = cin;
    end
  end

  // Operation select: result byte, flags and accumulator write.
  always_comb begin
    rsp_o.result = a;
    rsp_o.flags  = flags_i;
    rsp_o.acc_we = 1'b0;
    case (op)
      OP_ADD, OP_ADC: begin
        rsp_o.result = add_full[7:0];
        rsp_o.flags  = '{z: add_full[7:0] == 8'd0, n: 1'b0, h: add_half[4], c: add_full[8]};
        rsp_o.acc_we = 1'b1;
      end
      OP_SUB, OP_SBC: begin
        rsp_o.result = sub_full[7:0];
        rsp_o.flags  = '{z: sub_full[7:0] == 8'd0, n: 1'b1, h: sub_half[4], c: sub_full[8]};
        rsp_o.acc_we = 1'b1;
      end
      OP_CP: begin
        rsp_o.flags  = '{z: sub_full[7:0] == 8'd0, n: 1'b1, h: sub_half[4], c: sub_full[8]};
      end
      OP_AND: begin
        rsp_o.result = a & v;
        rsp_o.flags  = '{z: (a & v) == 8'd0, n: 1'b0, h: 1'b1, c: 1'b0};
        rsp_o.acc_we = 1'b1;
      end
      OP_XOR: begin
        rsp_o.result = a ^ v;
        rsp_o.flags  = '{z: (a ^ v) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
        rsp_o.acc_we = 1'b1;
      end
      OP_OR: begin
        rsp_o.result = a | v;
        rsp_o.flags  = '{z: (a | v) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
        rsp_o.acc_we = 1'b1;
      end
      OP_INC: begin
        rsp_o.result = v + 8'd1;
        rsp_o.flags  = '{z: v == 8'hFF, n: 1'b0, h: v[3:0] == 4'hF, c: cin};
      end
      OP_DEC: begin
        rsp_o.result = v - 8'd1;
        rsp_o.flags  = '{z: v == 8'h01, n: 1'b1, h: v[3:0] == 4'h0, c: cin};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        rsp_o.result = rot_r;
        rsp_o.flags  = '{z: rot_r == 8'd0, n: 1'b0, h: 1'b0, c: rot_co};
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        // The short accumulator forms always clear Z.
        rsp_o.result = rot_r;
        rsp_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_co};
        rsp_o.acc_we = 1'b1;
      end
      OP_BIT: begin
        rsp_o.result = v;
        rsp_o.flags  = '{z: (v & bit_mask) == 8'd0, n: 1'b0, h: 1'b1, c: cin};
      end
      OP_RES: begin
        rsp_o.result = v & ~bit_mask;
      end
      OP_SET: begin
        rsp_o.result = v | bit_mask;
      end
      OP_DAA: begin
        rsp_o.result = daa_r;
        rsp_o.flags  = '{z: daa_r == 8'd0, n: flags_i.n, h: 1'b0, c: daa_c};
        rsp_o.acc_we = 1'b1;
      end
      OP_CPL: begin
        rsp_o.result = ~a;
        rsp_o.flags  = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: cin};
        rsp_o.acc_we = 1'b1;
      end
      OP_CCF: begin
        rsp_o.flags  = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: !cin};
      end
      OP_SCF: begin
        rsp_o.flags  = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_LDA: begin
        rsp_o.result = v;
        rsp_o.acc_we = 1'b1;
      end
      default: begin
        // Unused codes leave everything as it is.
        rsp_o.result = a;
      end
    endcase
  end

endmodule

// ===== rtl/core/accalu_checker.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accalu_checker import accalu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // A stalled response keeps its valid and its payload.
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // A pending request is not withdrawn.
  `ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_req_i))

  // With no response waiting, the block always takes a request.
  `ASSERT_SAME(a_ready_when_empty, !out_valid_o, in_ready_o)

  // Every accepted request shows a valid response after the input and response registers.
  `ASSERT_SAME(a_resp_latency,
               $past(rst_ni, 2) && $past(rst_ni, 1) && $past(in_valid_i && in_ready_o, 2),
               out_valid_o)

endmodule

bind accumulator_alu_with_flags accalu_checker u_accalu_checker (.*);
